// ===== rtl/stop_and_wait_packet_receiver_core_assert.svh =====
// Assertion macros shared by the stop-and-wait receiver RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef STOP_AND_WAIT_PACKET_RECEIVER_CORE_ASSERT_SVH
`define STOP_AND_WAIT_PACKET_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWPR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/swpr_pkg.sv =====
// Shared types and constants for the stop-and-wait packet receiver.
// No dependencies; imported by the front, back and top-level modules.
package swpr_pkg;

    // Header layout (fixed ASCII-decimal header)
    localparam int HEADER_BYTES = 31;
    localparam int CSUM_LAST    = 5;
    localparam int SEQ_FIRST    = 10;
    localparam int SEQ_LAST     = 19;
    localparam int FLAG_POS     = 30;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CSUM_W = 20;
    localparam int SEQ_W  = 34;
    localparam int FLAG_W = 4;
    localparam int SUM_W  = 17;
    localparam int PLEN_W = 10;
    // Payload length carried between front and back; holds any legal packet size
    localparam int LEN_W  = 16;

    localparam logic [SUM_W-1:0] SUM_LIMIT   = 17'd131071;
    localparam logic [SEQ_W-1:0] ACK_MODULUS = 34'd10000000000;
    localparam logic [SEQ_W-1:0] ACK_RESET   = 34'd1;

    // Queue depths
    localparam int SUMMARY_DEPTH = 2;
    localparam int RESULT_DEPTH  = 2;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_BAD_CSUM  = 2'd2,
        ST_SHORT     = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              last;
    } t_in_word;

    typedef struct packed {
        t_status           status;
        logic [SEQ_W-1:0]  ack_number;
        logic [FLAG_W-1:0] end_flag;
        logic [PLEN_W-1:0] payload_length;
    } t_out_word;

    // Per-packet summary handed from the parser to the checker
    typedef struct packed {
        logic              short_pkt;
        logic [LEN_W-1:0]  plen;
        logic [CSUM_W-1:0] csum;
        logic [SEQ_W-1:0]  seq;
        logic [FLAG_W-1:0] flag;
        logic [SUM_W-1:0]  sum;
    } t_summary;

endpackage

// ===== rtl/swpr_fifo.sv =====
// Small register-based FIFO used for the summary and result queues.
// No dependencies.
module swpr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/swpr_front.sv =====
// Front end: parses the ASCII header and sums the payload, one word per cycle while i_accept is high.
// Depends on swpr_pkg; emits one summary per packet on the last word.
module swpr_front #(
    parameter int MAX_PACKET_BYTES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  swpr_pkg::t_in_word i_word,
    output logic               o_push,
    output swpr_pkg::t_summary o_summary
);

    import swpr_pkg::*;

    localparam int PW = $clog2(MAX_PACKET_BYTES + 1);

    logic [PW-1:0]     r_pos,  n_pos;
    logic [CSUM_W-1:0] r_csum, n_csum;
    logic [SEQ_W-1:0]  r_seq,  n_seq;
    logic [FLAG_W-1:0] r_flag, n_flag;
    logic [SUM_W-1:0]  r_sum,  n_sum;
    logic              r_zero, n_zero;
    logic [3:0]        digit;
    logic [SUM_W:0]    sum_ext;
    logic              short_pkt;

    // Only '1'..'9' carry a value; the low nibble is the digit then
    assign digit = (i_word.rx_byte >= 8'h31 && i_word.rx_byte <= 8'h39) ?
                   i_word.rx_byte[3:0] : 4'd0;
    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(i_word.rx_byte);

    always_comb begin
        n_pos  = r_pos;
        n_csum = r_csum;
        n_seq  = r_seq;
        n_flag = r_flag;
        n_sum  = r_sum;
        n_zero = r_zero;
        if (i_accept && !r_zero && r_pos < PW'(MAX_PACKET_BYTES)) begin
            if (i_word.rx_byte == '0) begin
                n_zero = 1'b1;
            end else begin
                if (r_pos < PW'(HEADER_BYTES)) begin
                    if (r_pos <= PW'(CSUM_LAST)) begin
                        n_csum = (r_csum << 3) + (r_csum << 1) + CSUM_W'(digit);
                    end else if (r_pos >= PW'(SEQ_FIRST) && r_pos <= PW'(SEQ_LAST)) begin
                        n_seq = (r_seq << 3) + (r_seq << 1) + SEQ_W'(digit);
                    end else if (r_pos == PW'(FLAG_POS)) begin
                        n_flag = digit;
                    end
                end else begin
                    n_sum = (sum_ext > {1'b0, SUM_LIMIT}) ?
                            SUM_W'(sum_ext - {1'b0, SUM_LIMIT}) : SUM_W'(sum_ext);
                end
                n_pos = r_pos + 1'b1;
            end
        end

        // Build the summary from the updated packet state
        short_pkt           = (n_pos < PW'(HEADER_BYTES));
        o_summary.short_pkt = short_pkt;
        o_summary.plen      = short_pkt ? '0 : LEN_W'(n_pos - PW'(HEADER_BYTES));
        o_summary.csum      = n_csum;
        o_summary.seq       = n_seq;
        o_summary.flag      = n_flag;
        o_summary.sum       = n_sum;
        o_push              = i_accept && i_word.last;

        // Drop per-packet state once the packet closes
        if (o_push) begin
            n_pos  = '0;
            n_csum = '0;
            n_seq  = '0;
            n_flag = '0;
            n_sum  = '0;
            n_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_csum <= '0;
            r_seq  <= '0;
            r_flag <= '0;
            r_sum  <= '0;
            r_zero <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_csum <= n_csum;
            r_seq  <= n_seq;
            r_flag <= n_flag;
            r_sum  <= n_sum;
            r_zero <= n_zero;
        end
    end

endmodule

// ===== rtl/swpr_back.sv =====
// Back end: checks each packet summary and advances the expected ACK.
// Depends on swpr_pkg; produces one result word per summary taken.
module swpr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  swpr_pkg::t_summary  i_summary,
    output swpr_pkg::t_out_word o_result
);

    import swpr_pkg::*;

    logic [SEQ_W-1:0]  r_ack,  n_ack;
    logic [FLAG_W-1:0] r_flag, n_flag;
    logic [SEQ_W:0]    ack_sum;
    logic [SEQ_W:0]    ack_wrap;
    logic [SEQ_W-1:0]  ack_adv;

    // Expected ACK stays below the modulus, so one subtract wraps it
    assign ack_sum  = {1'b0, r_ack} + (SEQ_W + 1)'(i_summary.plen);
    assign ack_wrap = ack_sum - {1'b0, ACK_MODULUS};
    assign ack_adv  = (ack_sum >= {1'b0, ACK_MODULUS}) ? ack_wrap[SEQ_W-1:0] :
                      ack_sum[SEQ_W-1:0];

    always_comb begin
        n_ack                   = r_ack;
        n_flag                  = r_flag;
        o_result.payload_length = i_summary.plen[PLEN_W-1:0];
        if (i_summary.short_pkt) begin
            o_result.status         = ST_SHORT;
            o_result.payload_length = '0;
        end else if (i_summary.csum != CSUM_W'(i_summary.sum)) begin
            o_result.status = ST_BAD_CSUM;
        end else if (i_summary.seq != r_ack) begin
            o_result.status = ST_DUPLICATE;
        end else begin
            o_result.status = ST_ACCEPTED;
            if (i_take) begin
                n_ack  = ack_adv;
                n_flag = i_summary.flag;
            end
        end
        o_result.ack_number = (o_result.status == ST_ACCEPTED) ? ack_adv : r_ack;
        o_result.end_flag   = (o_result.status == ST_ACCEPTED) ? i_summary.flag : r_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack  <= ACK_RESET;
            r_flag <= '0;
        end else begin
            r_ack  <= n_ack;
            r_flag <= n_flag;
        end
    end

endmodule

// ===== rtl/stop_and_wait_packet_receiver_core.sv =====
// Stop-and-wait packet receiver core: top level joining parser, checker and queues.
// Depends on swpr_pkg, swpr_fifo, swpr_front, swpr_back and the assertion header.
//
// Feed a packet one byte word per cycle with last set on its final word. The
// block takes one word every cycle while full is low; full rises only when
// the two-entry packet summary queue is occupied, which happens when the
// result side has not been drained. Each last word yields exactly one result
// word: status (accepted, duplicate, bad checksum or short), the ACK number
// to send, the flag digit of the last accepted packet and the payload length.
// A result passes through the summary queue register, then the result queue
// register; it waits in the summary queue while the result queue is full.
// The ACK update is a single add with a compare-and-subtract wrap, so back to
// back packets of one word each are handled at the full word rate while results are popped.
module stop_and_wait_packet_receiver_core #(
    parameter int MAX_PACKET_BYTES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input word queue side
    input  logic                push,
    output logic                full,
    input  swpr_pkg::t_in_word  i_word,
    // result queue side
    output logic                empty,
    input  logic                pop,
    output swpr_pkg::t_out_word o_result
);

    import swpr_pkg::*;

    `include "stop_and_wait_packet_receiver_core_assert.svh"

    logic      in_accept;
    logic      sum_push;
    t_summary  sum_wr;
    t_summary  sum_rd;
    logic      sum_full;
    logic      sum_empty;
    logic      take;
    t_out_word res_wr;
    logic      res_full;

    // Hold off input while the summary queue has no room for a closing word
    assign full      = sum_full;
    assign in_accept = push && !full;

    swpr_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_word),
        .o_push   (sum_push),
        .o_summary(sum_wr)
    );

    swpr_fifo #(
        .WIDTH($bits(t_summary)),
        .DEPTH(SUMMARY_DEPTH)
    ) u_sum_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (sum_push),
        .i_data (sum_wr),
        .o_full (sum_full),
        .i_pop  (take),
        .o_data (sum_rd),
        .o_empty(sum_empty)
    );

    // Advance the checker only when a summary waits and the result queue has room
    assign take = !sum_empty && !res_full;

    swpr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_summary(sum_rd),
        .o_result (res_wr)
    );

    swpr_fifo #(
        .WIDTH($bits(t_out_word)),
        .DEPTH(RESULT_DEPTH)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (take),
        .i_data (res_wr),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (o_result),
        .o_empty(empty)
    );

    `SWPR_ASSERT_IMPLY(a_sum_no_overflow, i_clk, i_rst_n, sum_push, !sum_full, "summary queue overflow")
    `SWPR_ASSERT_IMPLY(a_ack_range, i_clk, i_rst_n, !empty, o_result.ack_number < ACK_MODULUS, "ACK out of range")
    `SWPR_ASSERT_IMPLY(a_short_len, i_clk, i_rst_n, !empty && o_result.status == ST_SHORT, o_result.payload_length == '0, "short packet with length")
    `SWPR_ASSERT_NEXT(a_take_fills, i_clk, i_rst_n, take, !empty, "result lost after check")

endmodule
